[hw/rtl/kmd_pkg.sv]
// Shared constants, types and step tables for the knight move distance block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package kmd_pkg;

  // Board limits. MAX_COLS is a power of two so a square index is {row, col}.
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int CNT_W     = ADDR_W + 1;
  localparam int DIST_W    = 12;
  localparam int COORD_W   = 7;
  localparam int NB_W      = COORD_W + 1;
  localparam int OUT_W     = 13;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS = CFG_IDX_W'(1);

  localparam logic [COORD_W-1:0] BOARD_RESET = COORD_W'(8);
  localparam logic [COORD_W-1:0] ROWS_CAP    = COORD_W'(MAX_ROWS);
  localparam logic [COORD_W-1:0] COLS_CAP    = COORD_W'(MAX_COLS);
  localparam logic [OUT_W-1:0]   NO_PATH     = '1;
  localparam logic [CNT_W-1:0]   CELL_COUNT  = CNT_W'(CELLS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_FETCH,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } kmd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_query;
    logic clear;
    logic seed;
    logic pop;
    logic fetch;
    logic load_cur;
    logic scan;
    logic load_result;
  } kmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_ok;
    logic clear_last;
    logic search_more;
    logic scan_last;
    logic result_free;
  } kmd_status_t;

  // Row offset of knight step k.
  function automatic logic signed [2:0] step_dr(input logic [2:0] k);
    logic signed [2:0] d;
    case (k)
      3'd0, 3'd4: d = -3'sd2;
      3'd1, 3'd5: d = -3'sd1;
      3'd2, 3'd6: d = 3'sd1;
      default:    d = 3'sd2;
    endcase
    return d;
  endfunction

  // Column offset of knight step k.
  function automatic logic signed [2:0] step_dc(input logic [2:0] k);
    logic signed [2:0] d;
    case (k)
      3'd0, 3'd3: d = 3'sd1;
      3'd1, 3'd2: d = 3'sd2;
      3'd4, 3'd7: d = -3'sd1;
      default:    d = -3'sd2;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/kmd_query_if.sv]
// Query channel: source and destination squares with a valid/ready handshake.
// Depends on kmd_pkg for the coordinate width.
interface kmd_query_if;
  import kmd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] src_row;
  logic [COORD_W-1:0] src_col;
  logic [COORD_W-1:0] dst_row;
  logic [COORD_W-1:0] dst_col;

  modport source (output valid, src_row, src_col, dst_row, dst_col, input ready);
  modport sink   (input valid, src_row, src_col, dst_row, dst_col, output ready);
endinterface

[hw/rtl/kmd_result_if.sv]
// Result channel: the least move count, or all ones when there is no path.
// Depends on kmd_pkg for the result width.
interface kmd_result_if;
  import kmd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] min_moves;

  modport source (output valid, min_moves, input ready);
  modport sink   (input valid, min_moves, output ready);
endinterface

[hw/rtl/kmd_cfg_if.sv]
// Configuration write channel: register index and write data with valid/ready.
// Depends on kmd_pkg for the index and data widths.
interface kmd_cfg_if;
  import kmd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/knight_move_distance.sv]
// Knight move distance: breadth-first search over a board of up to 64 x 64 squares.
// From acceptance to a valid result, an off-board query goes straight to the result; otherwise
// the search clears the map, seeds the source, expands each square taken from the queue (one
// map read port) and then finishes. One query at a time; the next is taken in the idle state
// that follows the loading of the result.
// Reset: board size returns to 8 x 8 and control clears; the map is swept per on-board query.
module knight_move_distance (
  input  logic         clk,
  input  logic         rst,
  kmd_query_if.sink    query,
  kmd_result_if.source result,
  kmd_cfg_if.sink      cfg
);
  import kmd_pkg::*;

  kmd_cmd_t    cmd;
  kmd_status_t status;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  // Controller.
  kmd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query.valid),
    .query_ready (query.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath.
  kmd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .src_row      (query.src_row),
    .src_col      (query.src_col),
    .dst_row      (query.dst_row),
    .dst_col      (query.dst_col),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.min_moves)
  );

endmodule

[hw/rtl/kmd_ctrl.sv]
// Controller state machine for the knight move distance search.
// Depends on kmd_pkg for the state, command and status types.
module kmd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                query_valid,
  output logic                query_ready,
  input  kmd_pkg::kmd_status_t status,
  output kmd_pkg::kmd_cmd_t    cmd
);
  import kmd_pkg::*;

  kmd_state_t state;
  kmd_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_valid) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (!status.query_ok) state_next = ST_DONE;
        else if (status.clear_last) state_next = ST_SEED;
      end
      ST_SEED: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        state_next = status.search_more ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_POP;
      end
      ST_DONE: begin
        if (status.result_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    cmd         = '0;
    query_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        query_ready    = 1'b1;
        cmd.load_query = query_valid;
      end
      ST_CLEAR: begin
        cmd.clear = status.query_ok;
      end
      ST_SEED: begin
        cmd.seed = 1'b1;
      end
      ST_POP: begin
        cmd.pop = status.search_more;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_LOAD: begin
        cmd.load_cur = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DONE: begin
        cmd.load_result = status.result_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/kmd_datapath.sv]
// Datapath of the knight move distance search: board registers, distance map,
// square queue, neighbor generation and the result register. Depends on kmd_pkg.
module kmd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  kmd_pkg::kmd_cmd_t                cmd,
  output kmd_pkg::kmd_status_t             status,
  input  logic [kmd_pkg::COORD_W-1:0]      src_row,
  input  logic [kmd_pkg::COORD_W-1:0]      src_col,
  input  logic [kmd_pkg::COORD_W-1:0]      dst_row,
  input  logic [kmd_pkg::COORD_W-1:0]      dst_col,
  input  logic                             cfg_we,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmd_pkg::CFG_DAT_W-1:0]    cfg_data,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic signed [kmd_pkg::OUT_W-1:0] result_value
);
  import kmd_pkg::*;

  logic [COORD_W-1:0] board_rows;
  logic [COORD_W-1:0] board_cols;
  logic [COORD_W-1:0] rows_used;
  logic [COORD_W-1:0] cols_used;

  logic               query_ok;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  dst_addr;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [CNT_W-1:0]   head;
  logic [CNT_W-1:0]   tail;
  logic               found;
  logic [DIST_W-1:0]  found_dist;

  logic [ADDR_W-1:0]  cur_addr;
  logic [DIST_W-1:0]  cur_dist;
  logic [DIST_W-1:0]  next_dist;
  logic [2:0]         step;

  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;
  logic               pend_wr;

  logic signed [NB_W-1:0] nb_row;
  logic signed [NB_W-1:0] nb_col;
  logic                   nb_ok;
  logic [ADDR_W-1:0]      nb_addr;

  // Distance map entry is {visited, distance}.
  logic [DIST_W:0]   map_mem [CELLS];
  logic [DIST_W:0]   map_rdata;
  logic [ADDR_W-1:0] map_ra;
  logic [ADDR_W-1:0] map_wa;
  logic [DIST_W:0]   map_wd;
  logic              map_we;

  logic [ADDR_W-1:0] queue_mem [CELLS];
  logic [ADDR_W-1:0] queue_rdata;
  logic [ADDR_W-1:0] queue_wa;
  logic [ADDR_W-1:0] queue_wd;
  logic              queue_we;

  // Board size registers, saturated at the board limits when used.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_rows <= BOARD_RESET;
      board_cols <= BOARD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOARD_ROWS: board_rows <= cfg_data;
        REG_BOARD_COLS: board_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_used = (board_rows > ROWS_CAP) ? ROWS_CAP : board_rows;
  assign cols_used = (board_cols > COLS_CAP) ? COLS_CAP : board_cols;

  // Query capture: range check and conversion to 0-based square indexes.
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      query_ok <= (src_row != '0) && (src_row <= rows_used) &&
                  (src_col != '0) && (src_col <= cols_used) &&
                  (dst_row != '0) && (dst_row <= rows_used) &&
                  (dst_col != '0) && (dst_col <= cols_used);
      src_addr <= {ROW_W'(src_row - 1'b1), COL_W'(src_col - 1'b1)};
      dst_addr <= {ROW_W'(dst_row - 1'b1), COL_W'(dst_col - 1'b1)};
    end
  end

  // Sweep counter for clearing the map at the start of a query.
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Current square being expanded and its distance.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      cur_addr <= queue_rdata;
    end
    if (cmd.load_cur) begin
      cur_dist <= map_rdata[DIST_W-1:0];
    end
  end

  assign next_dist = cur_dist + 1'b1;

  // Step counter over the eight knight moves.
  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      step <= '0;
    end else if (cmd.scan) begin
      step <= step + 1'b1;
    end
  end

  // Neighbor square of the current square for the present step.
  always_comb begin
    nb_row  = signed'(NB_W'(cur_addr[ADDR_W-1:COL_W])) + NB_W'(step_dr(step));
    nb_col  = signed'(NB_W'(cur_addr[COL_W-1:0])) + NB_W'(step_dc(step));
    nb_ok   = (nb_row >= 0) && (nb_row < signed'({1'b0, rows_used})) &&
              (nb_col >= 0) && (nb_col < signed'({1'b0, cols_used}));
    nb_addr = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
  end

  // A neighbor read in the previous cycle is checked against the map now.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.scan && nb_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pend_addr <= nb_addr;
    end
  end

  assign pend_wr = pend && !map_rdata[DIST_W];

  // Queue pointers and the found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      found <= 1'b0;
    end else if (cmd.seed) begin
      head  <= '0;
      tail  <= CNT_W'(1);
      found <= (src_addr == dst_addr);
    end else begin
      if (cmd.pop) begin
        head <= head + 1'b1;
      end
      if (pend_wr && (tail < CELL_COUNT)) begin
        tail <= tail + 1'b1;
      end
      if (pend_wr && (pend_addr == dst_addr)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      found_dist <= '0;
    end else if (pend_wr && (pend_addr == dst_addr)) begin
      found_dist <= next_dist;
    end
  end

  // Distance map port selection.
  always_comb begin
    map_ra = cmd.fetch ? queue_rdata : nb_addr;
    map_we = cmd.clear || cmd.seed || pend_wr;
    if (cmd.clear) begin
      map_wa = clr_cnt;
      map_wd = '0;
    end else if (cmd.seed) begin
      map_wa = src_addr;
      map_wd = {1'b1, DIST_W'(0)};
    end else begin
      map_wa = pend_addr;
      map_wd = {1'b1, next_dist};
    end
  end

  // Distance map memory with registered read.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rdata <= map_mem[map_ra];
  end

  // Square queue port selection.
  always_comb begin
    queue_we = cmd.seed || (pend_wr && (tail < CELL_COUNT));
    queue_wa = cmd.seed ? '0 : tail[ADDR_W-1:0];
    queue_wd = cmd.seed ? src_addr : pend_addr;
  end

  // Square queue memory with registered read at the head.
  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[queue_wa] <= queue_wd;
    end
    queue_rdata <= queue_mem[head[ADDR_W-1:0]];
  end

  // Result register, holds one finished answer until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result_value <= (query_ok && found) ? signed'({1'b0, found_dist})
                                          : signed'(NO_PATH);
    end
  end

  // Status back to the controller.
  always_comb begin
    status.query_ok    = query_ok;
    status.clear_last  = (clr_cnt == '1);
    status.search_more = (head < tail) && !found;
    status.scan_last   = (step == 3'd7);
    status.result_free = !result_valid || result_ready;
  end

endmodule
